/* rtl/c3rq_pkg.sv */
// ----------------------------------------------------------------------------
// c3rq_pkg: shared types and helpers
// Sizes, item codes, chain link types and the requantizer for the 3x3 conv.
// ----------------------------------------------------------------------------
package c3rq_pkg;

  localparam int IN_CH      = 16;
  localparam int OUT_CH     = 16;
  localparam int MAX_W      = 32;
  localparam int TAPS       = 9;
  localparam int MAX_H      = 4096;
  localparam int BANK_DEPTH = ((MAX_W + 2) / 3) * IN_CH;

  localparam logic [1:0] KIND_BIAS   = 2'd0;
  localparam logic [1:0] KIND_WEIGHT = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic signed [7:0]  byte_t;
  typedef logic signed [19:0] psum_t;

  typedef struct packed {
    logic       v;
    logic [3:0] co;
    logic [3:0] ci;
  } iss_t;

  typedef struct packed {
    logic             v;
    logic [3:0]       co;
    logic [3:0]       ci;
    logic [8:0][7:0]  pix;
    psum_t            psum;
  } link_t;

  typedef struct packed {
    logic [2:0][3:0] cls_q;
    logic [2:0][1:0] ky_slot;
    logic [2:0][1:0] kx_cls;
  } win_t;

  // (a - b) mod 3 for a, b in 0..2
  function automatic logic [1:0] sub3(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] d;
    d = {1'b0, a} + 3'd3 - {1'b0, b};
    if (d >= 3'd3) begin
      d = d - 3'd3;
    end
    return d[1:0];
  endfunction

  function automatic byte_t requant(input logic [31:0] acc);
    logic signed [23:0] sh;
    sh = 24'($signed(acc) >>> 8);
    if (sh > 24'sd127) begin
      return 8'sd127;
    end else if (sh < -24'sd128) begin
      return -8'sd128;
    end
    return sh[7:0];
  endfunction

endpackage

/* rtl/c3rq_line.sv */
// ----------------------------------------------------------------------------
// c3rq_line: three-row line store
// Nine banks by row slot and column mod 3; one read per bank gives the 3x3
// window of one input channel, rotated into tap order.
// ----------------------------------------------------------------------------
module c3rq_line (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                wr_en,
  input  logic [3:0]          wr_bank,
  input  logic [7:0]          wr_addr,
  input  c3rq_pkg::byte_t     wr_data,
  input  c3rq_pkg::iss_t      iss,
  input  c3rq_pkg::win_t      win,
  output c3rq_pkg::link_t     link_o
);

  logic [8:0][7:0] rd;
  c3rq_pkg::iss_t  iss_r;

  for (genvar b = 0; b < 9; b++) begin : g_bank
    c3rq_pkg::byte_t mem [c3rq_pkg::BANK_DEPTH];
    c3rq_pkg::byte_t rd_r;
    logic [7:0]      rd_addr;

    assign rd_addr = {win.cls_q[b % 3], iss.ci};

    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == 4'(b)) begin
        mem[wr_addr] <= wr_data;
      end
      if (en) begin
        rd_r <= mem[rd_addr];
      end
    end

    assign rd[b] = rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r <= '0;
    end else if (en) begin
      iss_r <= iss;
    end
  end

  always_comb begin
    link_o      = '0;
    link_o.v    = iss_r.v;
    link_o.co   = iss_r.co;
    link_o.ci   = iss_r.ci;
    link_o.psum = '0;
    for (int ky = 0; ky < 3; ky++) begin
      for (int kx = 0; kx < 3; kx++) begin
        link_o.pix[ky * 3 + kx] =
          rd[4'(win.ky_slot[ky]) * 4'd3 + 4'(win.kx_cls[kx])];
      end
    end
  end

endmodule

/* rtl/c3rq_cell.sv */
// ----------------------------------------------------------------------------
// c3rq_cell: one kernel tap of the MAC chain
// Holds the weights of its tap, multiplies its pixel and adds the product to
// the partial sum handed on to the next cell.
// ----------------------------------------------------------------------------
module c3rq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [3:0]          tap_id,
  input  logic                w_we,
  input  logic [7:0]          w_addr,
  input  c3rq_pkg::byte_t     w_data,
  input  c3rq_pkg::link_t     link_i,
  output c3rq_pkg::link_t     link_o
);

  c3rq_pkg::byte_t       wmem [256];
  c3rq_pkg::byte_t       w_r;
  logic signed [15:0]    prod_r;
  c3rq_pkg::link_t       a_r, b_r, c_r;
  c3rq_pkg::link_t       c_nxt;

  always_comb begin
    c_nxt      = b_r;
    c_nxt.psum = b_r.psum + 20'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_addr] <= w_data;
    end
    if (en) begin
      w_r    <= wmem[{link_i.co, link_i.ci}];
      prod_r <= w_r * $signed(a_r.pix[tap_id]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
      c_r <= '0;
    end else if (en) begin
      a_r <= link_i;
      b_r <= a_r;
      c_r <= c_nxt;
    end
  end

  assign link_o = c_r;

endmodule

/* rtl/c3rq_acc.sv */
// ----------------------------------------------------------------------------
// c3rq_acc: channel accumulator and result register
// Adds bias and per-channel tap sums, requantizes and holds the result.
// ----------------------------------------------------------------------------
module c3rq_acc (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                bias_we,
  input  logic [3:0]          bias_addr,
  input  logic [31:0]         bias_data,
  input  c3rq_pkg::link_t     link_i,
  input  logic [11:0]         row,
  input  logic [4:0]          col,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [11:0]         out_row,
  output logic [4:0]          out_col,
  output logic [3:0]          out_channel_index,
  output logic signed [7:0]   out_value,
  output logic                out_last
);

  logic [31:0] bias_r [c3rq_pkg::OUT_CH];
  logic [31:0] acc_r;
  logic [31:0] acc_nxt;
  logic        fire;
  logic        valid_r;

  assign acc_nxt = ((link_i.ci == 4'd0) ? bias_r[link_i.co] : acc_r) + 32'(link_i.psum);
  assign fire    = en && link_i.v && link_i.ci == 4'(c3rq_pkg::IN_CH - 1);

  always_ff @(posedge clk) begin
    if (bias_we) begin
      bias_r[bias_addr] <= bias_data;
    end
    if (en && link_i.v) begin
      acc_r <= acc_nxt;
    end
    if (fire) begin
      out_row           <= row;
      out_col           <= col;
      out_channel_index <= link_i.co;
      out_value         <= c3rq_pkg::requant(acc_nxt);
      out_last          <= (link_i.co == 4'(c3rq_pkg::OUT_CH - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  assign out_valid = valid_r;

endmodule

/* rtl/conv3x3_int8_requant_top.sv */
// ----------------------------------------------------------------------------
// conv3x3_int8_requant_top: 3x3 valid convolution with int8 requantization
// Bias and weight loads and feature samples that do not complete an output
// pixel do not stall the input. A sample that completes a pixel at row and
// column 2 or more starts 256 issue slots, one per output and input channel
// pair, through a chain of nine tap cells (one 8x8 multiplier each) and a
// channel accumulator; the input stalls until the sixteen results of that
// pixel are computed. A held result stalls the whole chain.
// ----------------------------------------------------------------------------
module conv3x3_int8_requant_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [12:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_kind,
  input  logic [3:0]          in_out_channel,
  input  logic [3:0]          in_in_channel,
  input  logic [3:0]          in_tap,
  input  logic signed [31:0]  in_bias_value,
  input  logic signed [7:0]   in_byte_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [11:0]         out_out_row,
  output logic [4:0]          out_out_col,
  output logic [3:0]          out_out_channel_index,
  output logic signed [7:0]   out_value,
  output logic                out_last
);

  logic [5:0]  width_r;
  logic [12:0] height_r;
  logic [5:0]  w_eff;
  logic [12:0] h_eff;

  logic [1:0]  slot_r;
  logic [4:0]  col_r;
  logic [1:0]  cm_r;
  logic [3:0]  cq_r;
  logic [11:0] row_r;
  logic [3:0]  ch_r;

  logic        busy_r;
  logic        seq_on_r;
  logic [3:0]  seq_co_r;
  logic [3:0]  seq_ci_r;
  logic [11:0] res_row_r;
  logic [4:0]  res_col_r;
  c3rq_pkg::win_t win_r;
  c3rq_pkg::win_t win_nxt;

  logic        in_acc;
  logic        is_sample;
  logic        trig;
  logic        en;
  logic        done;
  logic [5:0]  col_inc;
  logic [12:0] row_inc;
  logic [1:0]  kxm;
  c3rq_pkg::iss_t  iss;
  c3rq_pkg::link_t chain [10];

  assign w_eff = (width_r < 6'd3) ? 6'd3 :
                 (width_r > 6'(c3rq_pkg::MAX_W)) ? 6'(c3rq_pkg::MAX_W) : width_r;
  assign h_eff = (height_r < 13'd3) ? 13'd3 :
                 (height_r > 13'(c3rq_pkg::MAX_H)) ? 13'(c3rq_pkg::MAX_H) : height_r;

  assign in_stall  = busy_r;
  assign in_acc    = in_valid && !in_stall;
  assign is_sample = in_acc && in_kind == c3rq_pkg::KIND_SAMPLE;
  assign trig      = is_sample && ch_r == 4'(c3rq_pkg::IN_CH - 1)
                     && col_r >= 5'd2 && row_r >= 12'd2;
  assign en        = !out_valid || !out_stall;
  assign done      = en && chain[9].v && chain[9].co == 4'(c3rq_pkg::OUT_CH - 1)
                     && chain[9].ci == 4'(c3rq_pkg::IN_CH - 1);
  assign col_inc   = {1'b0, col_r} + 6'd1;
  assign row_inc   = {1'b0, row_r} + 13'd1;

  always_comb begin
    win_nxt = '0;
    kxm     = '0;
    for (int k = 0; k < 3; k++) begin
      win_nxt.ky_slot[k] = c3rq_pkg::sub3(slot_r, 2'(k));
      win_nxt.kx_cls[k]  = c3rq_pkg::sub3(cm_r, 2'(k));
      kxm                = c3rq_pkg::sub3(cm_r, 2'(k));
      win_nxt.cls_q[k]   = (cm_r >= kxm) ? cq_r : cq_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 6'd26;
      height_r <= 13'd26;
    end else if (cfg_we) begin
      case (cfg_index)
        c3rq_pkg::REG_WIDTH:  width_r  <= cfg_data[5:0];
        c3rq_pkg::REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      col_r  <= '0;
      cm_r   <= '0;
      cq_r   <= '0;
      row_r  <= '0;
      ch_r   <= '0;
    end else if (is_sample) begin
      if (ch_r == 4'(c3rq_pkg::IN_CH - 1)) begin
        ch_r <= '0;
        if (col_inc >= w_eff) begin
          col_r  <= '0;
          cm_r   <= '0;
          cq_r   <= '0;
          slot_r <= (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
          row_r  <= (row_inc >= h_eff) ? 12'd0 : row_inc[11:0];
        end else begin
          col_r <= col_inc[4:0];
          if (cm_r == 2'd2) begin
            cm_r <= 2'd0;
            cq_r <= cq_r + 4'd1;
          end else begin
            cm_r <= cm_r + 2'd1;
          end
        end
      end else begin
        ch_r <= ch_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      seq_on_r <= 1'b0;
      seq_co_r <= '0;
      seq_ci_r <= '0;
    end else if (trig) begin
      busy_r   <= 1'b1;
      seq_on_r <= 1'b1;
      seq_co_r <= '0;
      seq_ci_r <= '0;
    end else begin
      if (done) begin
        busy_r <= 1'b0;
      end
      if (en && seq_on_r) begin
        {seq_co_r, seq_ci_r} <= {seq_co_r, seq_ci_r} + 8'd1;
        if (seq_co_r == 4'(c3rq_pkg::OUT_CH - 1) && seq_ci_r == 4'(c3rq_pkg::IN_CH - 1)) begin
          seq_on_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (trig) begin
      win_r     <= win_nxt;
      res_row_r <= row_r - 12'd2;
      res_col_r <= col_r - 5'd2;
    end
  end

  assign iss.v  = seq_on_r;
  assign iss.co = seq_co_r;
  assign iss.ci = seq_ci_r;

  c3rq_line u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .wr_en   (is_sample),
    .wr_bank (4'(slot_r) * 4'd3 + 4'(cm_r)),
    .wr_addr ({cq_r, ch_r}),
    .wr_data (in_byte_value),
    .iss     (iss),
    .win     (win_r),
    .link_o  (chain[0])
  );

  for (genvar t = 0; t < c3rq_pkg::TAPS; t++) begin : g_cell
    c3rq_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .tap_id (4'(t)),
      .w_we   (in_acc && in_kind == c3rq_pkg::KIND_WEIGHT && in_tap == 4'(t)),
      .w_addr ({in_out_channel, in_in_channel}),
      .w_data (in_byte_value),
      .link_i (chain[t]),
      .link_o (chain[t + 1])
    );
  end

  c3rq_acc u_acc (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (en),
    .bias_we           (in_acc && in_kind == c3rq_pkg::KIND_BIAS),
    .bias_addr         (in_out_channel),
    .bias_data         (in_bias_value),
    .link_i            (chain[9]),
    .row               (res_row_r),
    .col               (res_col_r),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_row           (out_out_row),
    .out_col           (out_out_col),
    .out_channel_index (out_out_channel_index),
    .out_value         (out_value),
    .out_last          (out_last)
  );

  a_seq_busy: assert property (@(posedge clk) disable iff (!rst_n)
    seq_on_r |-> busy_r)
    else $error("issue active while block idle");

  a_chain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    chain[9].v |-> busy_r)
    else $error("chain output without pending pixel");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (out_valid && out_last && !busy_r))
    else $error("final channel not flagged last");

endmodule
